[hw/rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// Register indexes, field widths and the compare settings that each cell sees.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int ADDR_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_BASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFS   = 3'd5;

    // compare settings broadcast along the row of cells
    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [PAT_BYTES-1:0]   care;
        logic [LEN_W-1:0]       len;
    } t_cell_cfg;

endpackage

[hw/rtl/mbps_cell.sv]
// ----------------------------------------------------------------------------
// mbps_cell: one position of the byte window
// Holds one window byte, passes it to the next cell on a shift and checks the
// incoming byte against the pattern byte that lines up with this position.
// ----------------------------------------------------------------------------
module mbps_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_clear,
    input  logic [7:0]         i_byte,
    input  mbps_pkg::t_cell_cfg i_cfg,
    output logic [7:0]         o_byte,
    output logic               o_ok
);

    localparam logic [mbps_pkg::LEN_W-1:0] K = mbps_pkg::LEN_W'(IDX);

    logic [7:0]                 r_byte;
    logic [mbps_pkg::LEN_W-1:0] pat_sel;
    logic [3:0]                 j;
    logic [7:0]                 pat_byte;
    logic                       in_use;

    // window position k lines up with pattern byte len-1-k
    assign in_use   = i_cfg.len > K;
    assign pat_sel  = i_cfg.len - K - mbps_pkg::LEN_W'(1);
    assign j        = pat_sel[3:0];
    assign pat_byte = i_cfg.pattern[{j, 3'b000} +: 8];
    assign o_ok     = !in_use || !i_cfg.care[j] || (pat_byte == i_byte);
    assign o_byte   = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_clear) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

[hw/rtl/masked_byte_pattern_scan_top.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_top: wildcard byte signature scanner
// Streams image bytes through a row of window cells, reports the first masked
// pattern match of each image or a not-found beat on its final byte.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  input    in         i_valid / o_ready       i_data_byte, i_last_byte
//  result   out        o_valid / i_ready       o_found, o_match_address
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one byte accepted per cycle while o_ready is high; the compare over all cells is combinational
//  a result passes through the compare stage, then the address add into the output register
//  o_ready drops only when both the compare stage and output register are full
//  and the output is stalled
//  reset (synchronous) clears the window, position and match flag and loads
//  the register defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_top #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_found,
    output logic [mbps_pkg::ADDR_W-1:0]        o_match_address,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [mbps_pkg::LEN_W-1:0] LEN_MAX = mbps_pkg::LEN_W'(PATTERN_MAX);

    // configuration registers
    logic [63:0]                     r_pat_low;
    logic [63:0]                     r_pat_high;
    logic [15:0]                     r_care;
    logic [mbps_pkg::LEN_W-1:0]      r_len;
    logic [mbps_pkg::ADDR_W-1:0]     r_base;
    logic [mbps_pkg::ADDR_W-1:0]     r_ofs;
    logic [mbps_pkg::ADDR_W-1:0]     r_base_ofs;

    // scan state
    logic [mbps_pkg::ADDR_W-1:0]     r_pos;
    logic                            r_reported;

    // compare stage and output register
    logic                            r_s1_valid;
    logic                            r_s1_found;
    logic [mbps_pkg::ADDR_W-1:0]     r_s1_start;
    logic                            r_out_valid;
    logic                            r_found;
    logic [mbps_pkg::ADDR_W-1:0]     r_addr;

    logic                            accept;
    logic                            out_take;
    logic                            s1_free;
    logic                            shift;
    logic                            clear;
    logic                            produce;
    logic                            hit;
    logic                            pos_ok;
    logic [mbps_pkg::LEN_W-1:0]      len;
    logic [mbps_pkg::LEN_W-1:0]      len_m1;
    logic [mbps_pkg::ADDR_W-1:0]     start;
    logic [PATTERN_MAX-1:0]          cell_ok;
    logic [7:0]                      win [PATTERN_MAX];
    mbps_pkg::t_cell_cfg             cell_cfg;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '1;
            r_len      <= mbps_pkg::LEN_W'(16);
            r_base     <= '0;
            r_ofs      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                mbps_pkg::CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                mbps_pkg::CFG_CARE_MASK:    r_care     <= i_cfg_data[15:0];
                mbps_pkg::CFG_PATTERN_LEN:  r_len      <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_IMAGE_BASE:   r_base     <= i_cfg_data[mbps_pkg::ADDR_W-1:0];
                mbps_pkg::CFG_RESULT_OFS:   r_ofs      <= i_cfg_data[mbps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // base plus offset is registered from the base and offset registers
    always_ff @(posedge i_clk) begin
        r_base_ofs <= r_base + r_ofs;
    end

    assign len    = (r_len > LEN_MAX) ? LEN_MAX : r_len;
    assign len_m1 = (len == '0) ? '0 : len - mbps_pkg::LEN_W'(1);

    assign cell_cfg.pattern = {r_pat_high, r_pat_low};
    assign cell_cfg.care    = r_care;
    assign cell_cfg.len     = len;

    // handshake
    assign out_take = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_take;
    assign o_ready  = s1_free;
    assign accept   = i_valid && s1_free;
    assign shift    = accept && !r_reported;
    assign clear    = accept && i_last_byte;

    // row of window cells, cell 0 takes the newest byte
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [7:0] in_byte;
        if (k == 0) begin : g_head
            assign in_byte = i_data_byte;
        end else begin : g_link
            assign in_byte = win[k-1];
        end
        mbps_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_clear (clear),
            .i_byte  (in_byte),
            .i_cfg   (cell_cfg),
            .o_byte  (win[k]),
            .o_ok    (cell_ok[k])
        );
    end

    assign pos_ok  = r_pos >= mbps_pkg::ADDR_W'(len_m1);
    assign hit     = pos_ok && (&cell_ok);
    assign start   = r_pos - mbps_pkg::ADDR_W'(len_m1);
    assign produce = !r_reported && (hit || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_reported <= 1'b0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_pos      <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_pos      <= r_pos + mbps_pkg::ADDR_W'(1);
                r_reported <= hit;
            end
        end
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= produce;
        end else if (out_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_found <= hit;
            r_s1_start <= start;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_s1_valid) begin
            r_found <= r_s1_found;
            r_addr  <= r_s1_found ? (r_base_ofs + r_s1_start) : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

    // not-found beats carry a zero address
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_addr == '0))
        else $error("not-found beat with nonzero address");

    // the final byte always rearms the scan
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_pos == '0 && !r_reported))
        else $error("scan not rearmed after final byte");

    // bytes after a reported match give no beat
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_reported) |=> !r_s1_valid)
        else $error("beat produced after match was reported");

    // a match mid-image locks out the rest of that image
    a_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_reported && hit && !i_last_byte) |=> (r_reported && r_s1_valid))
        else $error("match not recorded");

endmodule

[tb/masked_byte_pattern_scan_top_tb.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_top_tb: self-checking bench for the signature scanner
// Streams byte images through the scanner with bursty input and a stalling
// result side, predicts each found / not-found beat from its own copy of the
// window and registers, and compares every result beat in order.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_top_tb;

    import mbps_pkg::*;

    // writes to these indexes are accepted but change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int TARGET_BYTES = 1900;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_result_t;

    class scan_scoreboard;
        logic [63:0]       pat_lo;
        logic [63:0]       pat_hi;
        logic [15:0]       care;
        logic [LEN_W-1:0]  plen;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] ofs;
        logic [7:0]        window [PAT_BYTES];
        logic [31:0]       pos;
        bit                reported;
        scan_result_t      hit_q [$];
        int                errors;

        function new();
            pat_lo = '0;
            pat_hi = '0;
            care   = 16'hFFFF;
            plen   = 5'd16;
            base   = '0;
            ofs    = '0;
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            foreach (window[k]) window[k] = 8'h00;
            pos      = '0;
            reported = 1'b0;
        endfunction

        function logic [7:0] pattern_byte(int j);
            logic [127:0] both;
            both = {pat_hi, pat_lo};
            return both[8*j +: 8];
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_PATTERN_LOW:  pat_lo = d;
                CFG_PATTERN_HIGH: pat_hi = d;
                CFG_CARE_MASK:    care   = d[15:0];
                CFG_PATTERN_LEN:  plen   = d[LEN_W-1:0];
                CFG_IMAGE_BASE:   base   = d[ADDR_W-1:0];
                CFG_RESULT_OFS:   ofs    = d[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted input beat: shift the window and look for a match
        function void note_byte(logic [7:0] b, logic lst);
            int unsigned  eff;
            logic [31:0]  start;
            bit           hit;
            scan_result_t r;
            if (reported) begin
                if (lst) rearm();
                return;
            end
            for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            eff   = (plen > PAT_BYTES) ? PAT_BYTES : plen;
            start = '0;
            if (eff == 0) begin
                hit   = 1'b1;
                start = pos;
            end else begin
                hit = (pos >= eff - 1);
                if (hit) begin
                    start = pos - (eff - 1);
                    for (int j = 0; j < eff; j++) begin
                        if (care[j] && pattern_byte(j) != window[eff-1-j]) hit = 1'b0;
                    end
                end
            end
            pos = pos + 1;
            if (hit) begin
                r.found = 1'b1;
                r.addr  = base + start + ofs;
                hit_q.push_back(r);
                if (lst) rearm();
                else reported = 1'b1;
            end else if (lst) begin
                r.found = 1'b0;
                r.addr  = '0;
                hit_q.push_back(r);
                rearm();
            end
        endfunction

        function void check_result(logic f, logic [ADDR_W-1:0] a);
            scan_result_t e;
            if (hit_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: found=%0b addr=%h", f, a);
                return;
            end
            e = hit_q.pop_front();
            if (f !== e.found || a !== e.addr) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                             e.found, e.addr, f, a);
            end
        endfunction

        function int pending();
            return hit_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic                  o_found;
    logic [ADDR_W-1:0]     o_match_address;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    scan_scoreboard sb = new();

    int  bytes_sent    = 0;
    int  burst_left    = 0;
    bit  steady        = 1'b1;
    bit  valid_dropped = 1'b1;
    int  ready_cycle   = 0;

    masked_byte_pattern_scan_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: check accepted beats, stall in modes picked by ready_cycle bits 9 and 8
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_found, o_match_address);
        ready_cycle <= ready_cycle + 1;
        case (ready_cycle[9:8])
            2'd0: i_ready <= 1'b1;
            2'd1: i_ready <= (ready_cycle[1:0] != 2'd3);
            2'd2: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // gap between bursts, skipped in steady stretches
    task automatic pace();
        if (steady) return;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_valid       <= 1'b0;
            valid_dropped  = 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        i_valid       <= 1'b1;
        valid_dropped  = 1'b0;
        i_data_byte   <= b;
        i_last_byte   <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b, lst);
        bytes_sent++;
        pace();
    endtask

    // quiet the input and let the pipeline empty
    task automatic settle();
        if (!valid_dropped) begin
            i_valid       <= 1'b0;
            valid_dropped  = 1'b1;
        end
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic write_all(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] care, input logic [4:0] plen,
                             input logic [31:0] base, input logic [31:0] ofs);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_CARE_MASK, {48'h0, care});
        write_reg(CFG_PATTERN_LEN, {59'h0, plen});
        write_reg(CFG_IMAGE_BASE, {32'h0, base});
        write_reg(CFG_RESULT_OFS, {32'h0, ofs});
        i_cfg_valid <= 1'b0;
    endtask

    // one image, optionally with the pattern planted and optionally left open
    task automatic send_image(input bit plant, input bit open_end);
        logic [7:0]  img [0:63];
        int unsigned eff;
        int          n;
        int          p;
        eff = (sb.plen > PAT_BYTES) ? PAT_BYTES : sb.plen;
        if (plant && eff > 0) n = $urandom_range(eff, eff + 20);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(25, 60);
        else n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) img[i] = 8'($urandom_range(0, 255));
        if (plant && eff > 0) begin
            p = $urandom_range(0, n - eff);
            for (int j = 0; j < eff; j++)
                if (sb.care[j]) img[p+j] = sb.pattern_byte(j);
        end
        for (int i = 0; i < n; i++) begin
            if (open_end && i == n - 1) break;
            send_byte(img[i], i == n - 1);
        end
    endtask

    task automatic random_config(input bit all_regs);
        logic [63:0] junk;
        logic [63:0] d;
        junk = rand64();
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0: d = '0;
                1: d = '1;
                default: d = rand64();
            endcase
            write_reg(CFG_PATTERN_LOW, d);
        end
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0: d = '0;
                1: d = '1;
                default: d = rand64();
            endcase
            write_reg(CFG_PATTERN_HIGH, d);
        end
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0: d = {junk[63:16], 16'h0000};
                1: d = {junk[63:16], 16'hFFFF};
                2: d = {junk[63:16], 16'(($urandom))};
                default: d = {junk[63:16], 16'($urandom | $urandom)};
            endcase
            write_reg(CFG_CARE_MASK, d);
        end
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0: d = {junk[63:5], 5'd0};
                1: d = {junk[63:5], 5'd16};
                2: d = {junk[63:5], 5'($urandom_range(17, 31))};
                3: d = {junk[63:5], 5'd1};
                default: d = {junk[63:5], 5'($urandom_range(1, 8))};
            endcase
            write_reg(CFG_PATTERN_LEN, d);
        end
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0: d = {junk[63:32], 32'h0000_0000};
                1: d = {junk[63:32], 32'hFFFF_FFFF};
                default: d = {junk[63:32], $urandom};
            endcase
            write_reg(CFG_IMAGE_BASE, d);
        end
        if (all_regs || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 6))
                0: d = {junk[63:32], 32'h0000_0000};
                1: d = {junk[63:32], 32'h8000_0000};
                2: d = {junk[63:32], 32'h7FFF_FFFF};
                3: d = {junk[63:32], 32'hFFFF_FFFF};
                default: d = {junk[63:32], $urandom};
            endcase
            write_reg(CFG_RESULT_OFS, d);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand64());
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_start;
        int phase_len;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: 16-byte pattern cannot fit a 3-byte image
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();

        // empty pattern matches on the first byte, the rest of the image is skipped
        write_all(64'h0, 64'h0, 16'hFFFF, 5'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b1);
        settle();

        // two-byte pattern landing on the final byte
        write_all(64'h0000_0000_0000_FF00, 64'h0, 16'h0003, 5'd2,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // single-byte images, hit and miss
        write_all(64'h0000_0000_0000_00AB, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 5'd1,
                  32'h0000_1000, 32'hFFFF_FFFF);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hAC, 1'b1);
        settle();

        random_config(1'b1);
        while (bytes_sent < TARGET_BYTES) begin
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 20);
            phase_start = bytes_sent;
            phase_len   = $urandom_range(60, 140);
            while (bytes_sent - phase_start < phase_len) begin
                send_image($urandom_range(0, 99) < 65, 1'b0);
                if ($urandom_range(0, 19) == 0) settle();
            end
            // sometimes leave an image open across the register change
            if ($urandom_range(0, 9) < 3) send_image($urandom_range(0, 1), 1'b1);
            settle();
            random_config(1'b0);
        end

        // close any open image
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        settle();
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
